/* design/mbrf_pkg.sv */
// Shared types, function codes and the CRC-16 byte update for the Modbus RTU request framer.
package mbrf_pkg;

   localparam logic [7:0]  FC_READ_COILS      = 8'h01;
   localparam logic [7:0]  FC_READ_HOLDING    = 8'h03;
   localparam logic [7:0]  FC_WRITE_COIL      = 8'h05;
   localparam logic [7:0]  FC_WRITE_COILS     = 8'h0F;
   localparam logic [7:0]  FC_WRITE_REGISTERS = 8'h10;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam int unsigned JOB_BYTES = 7;

   // Frame bookkeeping carried from one transaction to the next.
   typedef struct packed {
      logic [7:0]  latched_function;
      logic [15:0] items_remaining;
      logic [7:0]  coil_pack_byte;
      logic [2:0]  coil_bit_position;
      logic        frame_open;
   } frame_state_type;

   // Bytes one transaction puts on the wire; data[0] goes out first.
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] data;
      logic [2:0]                count;
      logic                      finish;
      logic                      restart;
   } job_type;

   // One byte through the reflected Modbus CRC-16, bit by bit.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] value);
      logic [15:0] c;
      c = crc ^ {8'h00, value};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* design/mbrf_decode.sv */
// Decodes one request transaction into the frame bytes it causes and the next frame state.
module mbrf_decode (
   input  logic                     req_type,
   input  logic [7:0]               slave_address,
   input  logic [7:0]               function_code,
   input  logic [15:0]              start_address,
   input  logic [15:0]              quantity,
   input  logic [15:0]              data_word,
   input  mbrf_pkg::frame_state_type state,
   output mbrf_pkg::frame_state_type state_next,
   output mbrf_pkg::job_type         job
);

   logic        known;
   logic [16:0] coil_sum;
   logic [7:0]  coil_byte;
   logic [7:0]  coil_bit;
   logic [15:0] items_dec;

   assign coil_sum  = {1'b0, quantity} + 17'd7;
   assign coil_bit  = 8'(data_word[0]) << state.coil_bit_position;
   assign coil_byte = state.coil_pack_byte | coil_bit;
   assign items_dec = state.items_remaining - 16'd1;

   always_comb begin
      case (function_code)
         mbrf_pkg::FC_READ_COILS, mbrf_pkg::FC_READ_HOLDING, mbrf_pkg::FC_WRITE_COIL,
         mbrf_pkg::FC_WRITE_COILS, mbrf_pkg::FC_WRITE_REGISTERS: known = 1'b1;
         default: known = 1'b0;
      endcase
   end

   always_comb begin
      state_next  = state;
      job.data    = '0;
      job.count   = 3'd0;
      job.finish  = 1'b0;
      job.restart = 1'b0;

      if (!req_type) begin
         // A header always opens a fresh frame, abandoning any open one.
         job.restart                  = 1'b1;
         state_next.latched_function  = function_code;
         state_next.items_remaining   = 16'd0;
         state_next.coil_pack_byte    = 8'd0;
         state_next.coil_bit_position = 3'd0;
         state_next.frame_open        = 1'b0;
         if (!known) begin
            job.finish = 1'b1;
         end else begin
            job.data[0] = slave_address;
            job.data[1] = function_code;
            job.data[2] = start_address[15:8];
            job.data[3] = start_address[7:0];
            if (function_code == mbrf_pkg::FC_WRITE_COIL) begin
               job.count                  = 3'd4;
               state_next.items_remaining = 16'd1;
               state_next.frame_open      = 1'b1;
            end else begin
               job.data[4] = quantity[15:8];
               job.data[5] = quantity[7:0];
               job.count   = 3'd6;
               if (function_code == mbrf_pkg::FC_WRITE_REGISTERS) begin
                  job.data[6] = {quantity[6:0], 1'b0};
                  job.count   = 3'd7;
               end else if (function_code == mbrf_pkg::FC_WRITE_COILS) begin
                  job.data[6] = coil_sum[10:3];
                  job.count   = 3'd7;
               end
               if ((function_code == mbrf_pkg::FC_WRITE_REGISTERS ||
                    function_code == mbrf_pkg::FC_WRITE_COILS) && quantity != 16'd0) begin
                  state_next.items_remaining = quantity;
                  state_next.frame_open      = 1'b1;
               end else begin
                  job.finish = 1'b1;
               end
            end
         end
      end else if (state.frame_open && state.items_remaining != 16'd0) begin
         state_next.items_remaining = items_dec;
         if (state.latched_function == mbrf_pkg::FC_WRITE_COILS) begin
            if (state.coil_bit_position == 3'd7 || items_dec == 16'd0) begin
               job.data[0]                  = coil_byte;
               job.count                    = 3'd1;
               state_next.coil_pack_byte    = 8'd0;
               state_next.coil_bit_position = 3'd0;
            end else begin
               state_next.coil_pack_byte    = coil_byte;
               state_next.coil_bit_position = state.coil_bit_position + 3'd1;
            end
         end else begin
            job.data[0] = data_word[15:8];
            job.data[1] = data_word[7:0];
            job.count   = 3'd2;
         end
         if (items_dec == 16'd0) begin
            job.finish                   = 1'b1;
            state_next.coil_pack_byte    = 8'd0;
            state_next.coil_bit_position = 3'd0;
            state_next.frame_open        = 1'b0;
         end
      end
   end

endmodule

/* design/modbus_rtu_request_framer_unit.sv */
// Top level of the Modbus RTU master request framer: decode, byte emitter and output register.
// Throughput: one frame byte per cycle while the output register is empty or being drained;
// a transaction causes up to eleven bytes, all sent by the single byte emitter with its per-byte CRC update.
// A transaction that causes no bytes never loads the job register; the next is accepted on the last byte.
// Reset (synchronous, active high) clears the frame state, sets the CRC to 0xFFFF and
// pad_enable to one, and empties the job and output registers.
module modbus_rtu_request_framer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_slave_address,
   input  logic [7:0]  req_function_code,
   input  logic [15:0] req_start_address,
   input  logic [15:0] req_quantity,
   input  logic [15:0] req_data_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last_byte,
   input  logic        csr_we,
   input  logic        csr_wdata
);

   // Configuration register.
   logic pad_enable_ff;

   // Frame bookkeeping, updated the moment a transaction is accepted.
   mbrf_pkg::frame_state_type state_ff, state_in;
   mbrf_pkg::job_type         job_in;

   // Job register: the current transaction's bytes, shifted out one per cycle when the emitter advances.
   logic                                job_valid_ff;
   logic [mbrf_pkg::JOB_BYTES-1:0][7:0] data_ff;
   logic [2:0]                          count_ff;
   logic [1:0]                          tail_ff;
   logic                                finish_ff;
   logic                                pad_ff;
   logic                                restart_ff;
   logic [15:0]                         crc_ff;

   // Output register.
   logic       rsp_valid_ff;
   logic [7:0] tx_byte_ff;
   logic       last_byte_ff;

   logic       accept;
   logic       advance;
   logic       job_last;
   logic       job_done;
   logic       job_nonempty;
   logic [15:0] crc_eff;
   logic [15:0] crc_in;
   logic [7:0]  byte_out;
   logic        last_out;

   mbrf_decode u_decode (
      .req_type      (req_type),
      .slave_address (req_slave_address),
      .function_code (req_function_code),
      .start_address (req_start_address),
      .quantity      (req_quantity),
      .data_word     (req_data_word),
      .state         (state_ff),
      .state_next    (state_in),
      .job           (job_in)
   );

   // The emitter moves one byte whenever the output register is empty or being drained.
   assign advance = job_valid_ff && (!rsp_valid_ff || rsp_ready);

   // The tail is CRC low, CRC high, then two zero pad bytes when padding is on.
   always_comb begin
      if (count_ff != 3'd0) begin
         job_last = (count_ff == 3'd1) && !finish_ff;
      end else begin
         job_last = (tail_ff == 2'd3) || (tail_ff == 2'd1 && !pad_ff);
      end
   end

   assign job_done     = advance && job_last;
   assign req_ready    = !job_valid_ff || job_done;
   assign accept       = req_valid && req_ready;
   assign job_nonempty = (job_in.count != 3'd0) || job_in.finish;

   // A header restarts the CRC at its first byte; otherwise the running value carries on.
   assign crc_eff = restart_ff ? mbrf_pkg::CRC_INIT : crc_ff;

   always_comb begin
      byte_out = 8'h00;
      last_out = 1'b0;
      crc_in   = crc_eff;
      if (count_ff != 3'd0) begin
         byte_out = data_ff[0];
         crc_in   = mbrf_pkg::crc_byte(crc_eff, data_ff[0]);
      end else begin
         case (tail_ff)
            2'd0: byte_out = crc_eff[7:0];
            2'd1: begin
               byte_out = crc_eff[15:8];
               last_out = !pad_ff;
               crc_in   = mbrf_pkg::CRC_INIT;
            end
            2'd2: byte_out = 8'h00;
            2'd3: last_out = 1'b1;
            default: byte_out = 8'h00;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_enable_ff <= 1'b1;
      end else if (csr_we) begin
         pad_enable_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         restart_ff   <= 1'b0;
         crc_ff       <= mbrf_pkg::CRC_INIT;
      end else begin
         if (advance) begin
            crc_ff <= crc_in;
         end
         // A job loading on the last byte of the one before it takes its own restart flag.
         if (accept && job_nonempty) begin
            job_valid_ff <= 1'b1;
            restart_ff   <= job_in.restart;
         end else begin
            if (job_done) begin
               job_valid_ff <= 1'b0;
            end
            if (advance) begin
               restart_ff <= 1'b0;
            end
         end
      end
   end

   // Payload of the job register.
   always_ff @(posedge clock) begin
      if (accept && job_nonempty) begin
         data_ff   <= job_in.data;
         count_ff  <= job_in.count;
         tail_ff   <= 2'd0;
         finish_ff <= job_in.finish;
         pad_ff    <= pad_enable_ff;
      end else if (advance) begin
         if (count_ff != 3'd0) begin
            data_ff  <= data_ff >> 8;
            count_ff <= count_ff - 3'd1;
         end else begin
            tail_ff <= tail_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tx_byte_ff   <= byte_out;
         last_byte_ff <= last_out;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tx_byte   = tx_byte_ff;
   assign rsp_last_byte = last_byte_ff;

endmodule
